// ----- sv/hdup_pkg.sv -----
package hdup_pkg;

  localparam logic [7:0] KEY_MASK  = 8'hfc;
  localparam logic [7:0] LONG_MASK = 8'hf0;
  localparam logic [1:0] LEN_BAD   = 2'h3;
  localparam logic [7:0] KEY_PAGE  = 8'h04;
  localparam logic [7:0] KEY_USAGE = 8'h08;

  typedef enum logic [1:0] {
    PH_TAG  = 2'd0,
    PH_DATA = 2'd1,
    PH_HIGH = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    TGT_NONE  = 2'd0,
    TGT_PAGE  = 2'd1,
    TGT_USAGE = 2'd2
  } target_t;

  typedef struct packed {
    logic        status;
    logic [15:0] usage;
    logic [15:0] page;
  } result_t;

endpackage

// ----- sv/hdup_parser.sv -----
module hdup_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              beat_acc,
  input  logic [7:0]        desc_byte,
  input  logic              last,
  output logic              res_valid,
  output hdup_pkg::result_t res
);

  hdup_pkg::phase_t  phase_r,  phase_nxt;
  hdup_pkg::target_t target_r, target_nxt;
  logic              two_r,    two_nxt;
  logic [7:0]        low_r,    low_nxt;
  logic [15:0]       page_r,   page_nxt;
  logic [15:0]       usage_r,  usage_nxt;
  logic              err_r,    err_nxt;

  logic [7:0]        key;
  logic [1:0]        len;
  logic              load;
  logic [15:0]       load_val;
  hdup_pkg::target_t load_tgt;

  assign key = desc_byte & hdup_pkg::KEY_MASK;
  assign len = desc_byte[1:0];

  always_comb begin
    phase_nxt  = phase_r;
    target_nxt = target_r;
    two_nxt    = two_r;
    low_nxt    = low_r;
    page_nxt   = page_r;
    usage_nxt  = usage_r;
    err_nxt    = err_r;
    load       = 1'b0;
    load_val   = '0;
    load_tgt   = target_r;

    if (!err_r) begin
      unique case (phase_r)
        hdup_pkg::PH_DATA: begin
          if (two_r) begin
            low_nxt   = desc_byte;
            two_nxt   = 1'b0;
            phase_nxt = hdup_pkg::PH_HIGH;
          end else begin
            load     = 1'b1;
            load_val = {8'h00, desc_byte};
          end
        end
        hdup_pkg::PH_HIGH: begin
          load     = 1'b1;
          load_val = {desc_byte, low_r};
        end
        default: begin
          // tag byte (unused phase code behaves the same)
          if ((key & hdup_pkg::LONG_MASK) == hdup_pkg::LONG_MASK || len == hdup_pkg::LEN_BAD) begin
            err_nxt = 1'b1;
          end else begin
            priority if (key == hdup_pkg::KEY_PAGE) begin
              load_tgt = hdup_pkg::TGT_PAGE;
            end else if (key == hdup_pkg::KEY_USAGE) begin
              load_tgt = hdup_pkg::TGT_USAGE;
            end else begin
              load_tgt = hdup_pkg::TGT_NONE;
            end
            target_nxt = load_tgt;
            if (len == 2'd0) begin
              load = 1'b1;
            end else begin
              two_nxt   = len[1];
              phase_nxt = hdup_pkg::PH_DATA;
            end
          end
        end
      endcase

      if (load) begin
        if (load_tgt == hdup_pkg::TGT_PAGE) begin
          page_nxt = load_val;
        end
        if (load_tgt == hdup_pkg::TGT_USAGE) begin
          usage_nxt = load_val;
        end
        phase_nxt  = hdup_pkg::PH_TAG;
        target_nxt = hdup_pkg::TGT_NONE;
        two_nxt    = 1'b0;
      end

      // descriptor ends with data still owed
      if (!err_nxt && last && phase_nxt != hdup_pkg::PH_TAG) begin
        err_nxt = 1'b1;
      end
    end
  end

  assign res_valid  = beat_acc && last;
  assign res.page   = page_nxt;
  assign res.usage  = usage_nxt;
  assign res.status = err_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || (beat_acc && last)) begin
      phase_r  <= hdup_pkg::PH_TAG;
      target_r <= hdup_pkg::TGT_NONE;
      two_r    <= 1'b0;
      low_r    <= '0;
      page_r   <= '0;
      usage_r  <= '0;
      err_r    <= 1'b0;
    end else if (beat_acc) begin
      phase_r  <= phase_nxt;
      target_r <= target_nxt;
      two_r    <= two_nxt;
      low_r    <= low_nxt;
      page_r   <= page_nxt;
      usage_r  <= usage_nxt;
      err_r    <= err_nxt;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    beat_acc && last |=> phase_r == hdup_pkg::PH_TAG && !err_r && page_r == '0 && usage_r == '0)
    else $error("parser state not cleared after last beat");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    err_r && !(beat_acc && last) |=> err_r)
    else $error("error flag dropped inside a descriptor");

  a_err_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    err_r && !(beat_acc && last) |=> $stable(page_r) && $stable(usage_r))
    else $error("usage registers changed after error");

endmodule

// ----- sv/hdup_out_buf.sv -----
module hdup_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  hdup_pkg::result_t push_data,
  output logic              ready,
  output logic              out_valid,
  input  logic              out_ready,
  output hdup_pkg::result_t out_data
);

  hdup_pkg::result_t mem_r [2];
  logic              wr_ptr_r, rd_ptr_r;
  logic [1:0]        count_r,  count_nxt;
  logic              pop;

  assign ready     = (count_r != 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> count_r != 2'd2)
    else $error("result pushed into full buffer");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("buffer count out of range");

  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd1) == (wr_ptr_r != rd_ptr_r))
    else $error("buffer pointers disagree with count");

endmodule

// ----- sv/hid_descriptor_usage_parser.sv -----
// HID report descriptor short-item parser. Takes one descriptor byte per
// beat on in_ (byte in in_tdata, in_tlast on the final byte) and, for every
// descriptor, returns one beat on out_, written into the output buffer
// when its last byte is accepted: the last usage page and usage values
// seen, and in out_tuser a malformed flag (long item, length code 3, or
// data cut off by the end of the descriptor). After an error the rest of
// the descriptor is skipped. Throughput is one byte per cycle while
// in_tready is high; the parse state updates on each accepted byte.
// Results sit in a two-entry output buffer; in_tready drops only when full.
module hid_descriptor_usage_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] desc_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] page, [31:16] usage
  output logic        out_tuser   // [0] status
);

  logic              beat_acc;
  logic              res_valid;
  hdup_pkg::result_t res;
  hdup_pkg::result_t out_res;

  assign beat_acc = in_tvalid && in_tready;

  hdup_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat_acc  (beat_acc),
    .desc_byte (in_tdata),
    .last      (in_tlast),
    .res_valid (res_valid),
    .res       (res)
  );

  hdup_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .ready     (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tdata = {out_res.usage, out_res.page};
  assign out_tuser = out_res.status;

endmodule

// ----- tb/sv/hid_descriptor_usage_parser_tb.sv -----
`timescale 1ns / 100ps

module hid_descriptor_usage_parser_tb;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned BYTE_TARGET = 1800;

  // Tracks the parse of the descriptor in flight and holds the results it owes.
  class descriptor_tracker;
    hdup_pkg::phase_t  phase;
    hdup_pkg::target_t target;
    logic [1:0]        bytes_due;
    logic [7:0]        low_byte;
    logic [15:0]       page_val;
    logic [15:0]       usage_val;
    logic              malformed;
    hdup_pkg::result_t expected_q[$];
    int unsigned       fail_count;

    function new();
      fail_count = 0;
      clear();
    endfunction

    function void clear();
      phase     = hdup_pkg::PH_TAG;
      target    = hdup_pkg::TGT_NONE;
      bytes_due = 2'd0;
      low_byte  = 8'h00;
      page_val  = 16'h0000;
      usage_val = 16'h0000;
      malformed = 1'b0;
    endfunction

    function void load(logic [15:0] v);
      if (target == hdup_pkg::TGT_PAGE) begin
        page_val = v;
      end else if (target == hdup_pkg::TGT_USAGE) begin
        usage_val = v;
      end
      phase     = hdup_pkg::PH_TAG;
      target    = hdup_pkg::TGT_NONE;
      bytes_due = 2'd0;
    endfunction

    function void note_byte(logic [7:0] b, logic fin);
      logic [7:0]        key;
      hdup_pkg::result_t res;
      key = b & hdup_pkg::KEY_MASK;
      if (!malformed) begin
        case (phase)
          hdup_pkg::PH_DATA: begin
            if (bytes_due == 2'd2) begin
              low_byte  = b;
              bytes_due = 2'd1;
              phase     = hdup_pkg::PH_HIGH;
            end else begin
              load({8'h00, b});
            end
          end
          hdup_pkg::PH_HIGH: begin
            load({b, low_byte});
          end
          default: begin
            if ((key & hdup_pkg::LONG_MASK) == hdup_pkg::LONG_MASK ||
                b[1:0] == hdup_pkg::LEN_BAD) begin
              malformed = 1'b1;
            end else begin
              if (key == hdup_pkg::KEY_PAGE) target = hdup_pkg::TGT_PAGE;
              else if (key == hdup_pkg::KEY_USAGE) target = hdup_pkg::TGT_USAGE;
              else target = hdup_pkg::TGT_NONE;
              if (b[1:0] == 2'd0) begin
                load(16'h0000);
              end else begin
                bytes_due = b[1:0];
                phase     = hdup_pkg::PH_DATA;
              end
            end
          end
        endcase
        // data still owed when the descriptor ends
        if (!malformed && fin && phase != hdup_pkg::PH_TAG) malformed = 1'b1;
      end
      if (fin) begin
        res.page   = page_val;
        res.usage  = usage_val;
        res.status = malformed;
        expected_q.push_back(res);
        clear();
      end
    endfunction

    function void check_result(logic [31:0] data, logic flag);
      hdup_pkg::result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result page=%h usage=%h status=%b",
                 $time, data[15:0], data[31:16], flag);
        fail_count++;
        return;
      end
      want = expected_q.pop_front();
      if (data[15:0] !== want.page) begin
        $display("%0t: page expected %h actual %h", $time, want.page, data[15:0]);
        fail_count++;
      end
      if (data[31:16] !== want.usage) begin
        $display("%0t: usage expected %h actual %h", $time, want.usage, data[31:16]);
        fail_count++;
      end
      if (flag !== want.status) begin
        $display("%0t: status expected %b actual %b", $time, want.status, flag);
        fail_count++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;

  descriptor_tracker tracker;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned burst_left = 0;
  logic [9:0]  stall_clk = '0;
  logic [8:0]  frame_q[$];  // {last, byte}

  // zero-length page, page+usage, two-byte data with a skipped item, zero-length
  // usage, long item, length code three, truncated data, truncated tag, null tag
  logic [8:0] directed_bytes [0:23] = '{
    9'h104,
    9'h005, 9'h001, 9'h009, 9'h102,
    9'h006, 9'h0ff, 9'h0ff, 9'h00a, 9'h034, 9'h012, 9'h0a1, 9'h101,
    9'h108,
    9'h0fe, 9'h105,
    9'h005, 9'h007, 9'h007, 9'h107,
    9'h006, 9'h112,
    9'h10a,
    9'h100
  };

  hid_descriptor_usage_parser uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: check accepted beats, stall on a rotating pattern
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_result(out_tdata, out_tuser);
    stall_clk <= stall_clk + 1'b1;
    case (stall_clk[9:8])
      2'd0: out_tready <= 1'b1;
      2'd1: out_tready <= ($urandom_range(0, 3) != 0);
      2'd2: out_tready <= (stall_clk[3:0] == 4'd0);
      default: out_tready <= 1'($urandom_range(0, 1));
    endcase
  end

  task automatic drive_byte(input logic [7:0] b, input logic fin);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    tracker.note_byte(b, fin);
    bytes_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 12);
    end
  endtask

  task automatic drain_results();
    if (in_tvalid) in_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.outstanding() != 0);
  endtask

  function automatic logic [7:0] data_byte();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // sel: 0 usage page, 1 usage, else a random short item (may also be page or usage)
  function automatic logic [7:0] short_tag(int sel, logic [1:0] len);
    logic [3:0] hi;
    logic [1:0] mid;
    hi  = 4'($urandom_range(0, 14));
    mid = 2'($urandom_range(0, 3));
    if (sel == 0) return hdup_pkg::KEY_PAGE | {6'd0, len};
    if (sel == 1) return hdup_pkg::KEY_USAGE | {6'd0, len};
    return {hi, mid, len};
  endfunction

  task automatic push_item();
    logic [1:0] len;
    len = 2'($urandom_range(0, 2));
    frame_q.push_back({1'b0, short_tag($urandom_range(0, 2), len)});
    repeat (len) frame_q.push_back({1'b0, data_byte()});
  endtask

  task automatic build_frame();
    int unsigned kind;
    int unsigned fault;
    logic [7:0]  tag;
    logic [8:0]  tail;
    logic [5:0]  key_bits;
    kind = $urandom_range(0, 99);
    frame_q.delete();
    if (kind < 80) begin
      repeat ($urandom_range(1, 6)) push_item();
    end else if (kind < 94) begin
      repeat ($urandom_range(0, 3)) push_item();
      fault = $urandom_range(0, 2);
      case (fault)
        0: frame_q.push_back({1'b0, 8'($urandom_range(240, 255))});
        1: begin
          key_bits = 6'($urandom_range(0, 63));
          frame_q.push_back({1'b0, key_bits, hdup_pkg::LEN_BAD});
        end
        default: begin
          tag = short_tag($urandom_range(0, 2), 2'($urandom_range(1, 2)));
          frame_q.push_back({1'b0, tag});
          if (tag[1:0] == 2'd2 && $urandom_range(0, 1) == 1)
            frame_q.push_back({1'b0, data_byte()});
        end
      endcase
      // bytes after a long item or bad length are skipped by the block
      if (fault != 2) repeat ($urandom_range(0, 4)) frame_q.push_back({1'b0, data_byte()});
    end else begin
      repeat ($urandom_range(1, 8)) frame_q.push_back({1'b0, 8'($urandom_range(0, 255))});
    end
    tail = frame_q.pop_back();
    frame_q.push_back({1'b1, tail[7:0]});
  endtask

  initial begin
    logic paused;
    paused = 1'b0;
    tracker = new();
    burst_left = $urandom_range(1, 20);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_bytes[i]) drive_byte(directed_bytes[i][7:0], directed_bytes[i][8]);
    drain_results();

    while (bytes_sent < BYTE_TARGET) begin
      build_frame();
      foreach (frame_q[i]) drive_byte(frame_q[i][7:0], frame_q[i][8]);
      if (!paused && bytes_sent > BYTE_TARGET / 2) begin
        paused = 1'b1;
        drain_results();
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (tracker.fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
